FILE: rtl/afef_pkg.sv
// Shared constants, types and coefficient tables for the audio FIR effect filter.
package afef_pkg;

  localparam int MAX_TAPS      = 12;
  localparam int COSINE_LENGTH = 13;

  localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int PHASE_W = (COSINE_LENGTH > 1) ? $clog2(COSINE_LENGTH) : 1;

  localparam int SMP_W  = 8;
  localparam int OFS_W  = 9;
  localparam int COEF_W = 11;
  localparam int PROD_W = OFS_W + COEF_W;
  localparam int ACC_W  = 20;

  localparam int MIDPOINT    = 127;
  localparam int SMP_MAX     = 255;
  localparam int COS_ENTRIES = 13;
  localparam int COEF_SLOTS  = 12;

  // truncating divide by 10 of a product magnitude below 2048
  localparam int CDIV_SHIFT = 14;
  localparam int CDIV_MULT  = 1639;
  localparam int CMAG_W     = 11;
  localparam int CQM_W      = CMAG_W + 11;
  localparam int CQ_W       = CQM_W - CDIV_SHIFT;
  localparam int CV_W       = 10;

  // floor divide by 500: bias the sum positive, multiply by reciprocal
  localparam int FIR_DIVISOR = 500;
  localparam int FDIV_BIAS   = 512;
  localparam int FDIV_SHIFT  = 28;
  localparam int FDIV_MULT   = 536871;
  localparam int FU_W        = 19;
  localparam int FQM_W       = FU_W + 20;
  localparam int FQ_W        = FQM_W - FDIV_SHIFT;
  localparam int FY_W        = FQ_W + 1;

  typedef enum logic [1:0] {
    MODE_HP       = 2'd0,
    MODE_LP       = 2'd1,
    MODE_BP       = 2'd2,
    MODE_SHIFT_HP = 2'd3
  } mode_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
  } mac_ctl_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t HP_COEF [COEF_SLOTS] = '{
    -11'sd18, -11'sd46, -11'sd83, -11'sd120, -11'sd148, 11'sd834,
    -11'sd148, -11'sd120, -11'sd83, -11'sd46, -11'sd18, 11'sd0};
  localparam coef_t LP_COEF [COEF_SLOTS] = '{
    11'sd37, 11'sd57, 11'sd77, 11'sd96, 11'sd111, 11'sd119,
    11'sd119, 11'sd111, 11'sd96, 11'sd77, 11'sd57, 11'sd37};
  localparam coef_t BP_COEF [COEF_SLOTS] = '{
    -11'sd69, -11'sd128, -11'sd109, 11'sd13, 11'sd170, 11'sd242,
    11'sd170, 11'sd13, -11'sd109, -11'sd128, -11'sd69, 11'sd0};
  localparam coef_t COS_TABLE [COS_ENTRIES] = '{
    11'sd10, 11'sd8, 11'sd5, 11'sd0, -11'sd4, -11'sd8, -11'sd9,
    -11'sd9, -11'sd6, -11'sd1, 11'sd3, 11'sd7, 11'sd9};

  function automatic logic [CNT_W-1:0] mode_taps(input mode_t m);
    int t;
    case (m)
      MODE_LP: t = 12;
      default: t = 11;
    endcase
    if (t > MAX_TAPS) t = MAX_TAPS;
    return CNT_W'(t);
  endfunction

  function automatic coef_t fir_coef(input mode_t m, input logic [TAP_W-1:0] idx);
    int k;
    coef_t c;
    k = int'(idx);
    c = '0;
    if (k < COEF_SLOTS) begin
      case (m)
        MODE_LP: c = LP_COEF[k];
        MODE_BP: c = BP_COEF[k];
        default: c = HP_COEF[k];
      endcase
    end
    return c;
  endfunction

  function automatic coef_t cos_coef(input logic [PHASE_W-1:0] phase);
    int k;
    coef_t c;
    k = int'(phase);
    c = '0;
    if (k < COS_ENTRIES) c = COS_TABLE[k];
    return c;
  endfunction

endpackage

FILE: rtl/afef_mac.sv
// Shared multiply-accumulate unit: registered product, added into the accumulator in the following cycle.
module afef_mac
  import afef_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [OFS_W-1:0]  op_a,
  input  logic signed [COEF_W-1:0] op_b,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     vld_r;
  logic                     first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      vld_r   <= ctl.mul_en & ctl.acc_en;
      first_r <= ctl.first;
    end
    if (ctl.mul_en) prod_r <= op_a * op_b;
    if (vld_r) begin
      if (first_r) acc_r <= ACC_W'(prod_r);
      else         acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

FILE: rtl/audio_fir_effect_filter.sv
// Audio FIR effect filter top level: sequencer, delay line, divide and saturate stages.
// One item in, at most one result out. Each item is taken by a sequencer that steps a single
// 9x11 multiplier through the window one tap per cycle. For an item that yields a result it
// shifts the delay line, runs the taps, drains the accumulator, then divides and saturates;
// shift then high-pass mode first forms the cosine product and its divide by 10. An item
// that only fills the window ends after the shift. The result sits in an output register,
// so the next item is accepted while it waits; the sequencer stalls only when a new result
// is ready and the previous one is still not taken. No result is given until the window for
// the current mode is full.
module audio_fir_effect_filter
  import afef_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SMP_W-1:0] in_tdata,   // [7:0] sample_in
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [SMP_W-1:0] out_tdata,  // [7:0] sample_out
  output logic             out_tuser,  // [0] clipped
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata   // filter_mode
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COS_MUL,
    S_COS_DIV,
    S_COS_FIX,
    S_SHIFT,
    S_MAC,
    S_DRAIN,
    S_DIV_MUL,
    S_DIV_FIX
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r;
  logic [SMP_W-1:0]   x_r, x_nxt;
  logic [SMP_W-1:0]   delay_r [MAX_TAPS];
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TAP_W-1:0]   tap_r, tap_nxt;
  logic [CQM_W-1:0]   cqm_r, cqm_nxt;
  logic               cneg_r, cneg_nxt;
  logic [FQM_W-1:0]   dqm_r, dqm_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]   out_sample_r, out_sample_nxt;
  logic               out_clip_r, out_clip_nxt;
  logic               shift_en;

  mac_ctl_t                 mac_ctl;
  logic signed [OFS_W-1:0]  mac_a;
  logic signed [COEF_W-1:0] mac_b;
  logic signed [PROD_W-1:0] mac_prod;
  logic signed [ACC_W-1:0]  mac_acc;

  logic [CNT_W-1:0]         taps;
  logic [CNT_W-1:0]         fill_inc;
  logic [CNT_W-1:0]         rd_cnt;
  logic [TAP_W-1:0]         rd_idx;
  logic [TAP_W-1:0]         last_tap;
  logic [SMP_W-1:0]         tap_smp;
  logic signed [PROD_W-1:0] pabs;
  logic [CQ_W-1:0]          cq;
  logic signed [CV_W-1:0]   cv;
  logic signed [ACC_W-1:0]  biased;
  logic [FQ_W-1:0]          fq;
  logic signed [FY_W-1:0]   fy;

  afef_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .prod  (mac_prod),
    .acc   (mac_acc)
  );

  assign taps     = mode_taps(mode_r);
  assign fill_inc = (fill_r < CNT_W'(MAX_TAPS)) ? fill_r + CNT_W'(1) : fill_r;
  assign rd_cnt   = taps - CNT_W'(1) - CNT_W'(tap_r);
  assign rd_idx   = rd_cnt[TAP_W-1:0];
  assign last_tap = TAP_W'(taps - CNT_W'(1));
  assign tap_smp  = delay_r[rd_idx];

  assign pabs   = mac_prod[PROD_W-1] ? -mac_prod : mac_prod;
  assign cq     = cqm_r[CQM_W-1:CDIV_SHIFT];
  assign cv     = cneg_r ? CV_W'(MIDPOINT) - CV_W'(cq) : CV_W'(MIDPOINT) + CV_W'(cq);
  assign biased = mac_acc + ACC_W'(FIR_DIVISOR * FDIV_BIAS);
  assign fq     = dqm_r[FQM_W-1:FDIV_SHIFT];
  assign fy     = signed'({1'b0, fq}) - FY_W'(FDIV_BIAS - MIDPOINT);

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    fill_nxt       = fill_r;
    phase_nxt      = phase_r;
    tap_nxt        = tap_r;
    cqm_nxt        = cqm_r;
    cneg_nxt       = cneg_r;
    dqm_nxt        = dqm_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;
    shift_en       = 1'b0;
    mac_ctl        = '0;
    mac_a          = signed'({1'b0, tap_smp}) - OFS_W'(MIDPOINT);
    mac_b          = fir_coef(mode_r, tap_r);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata;
          state_nxt = (mode_r == MODE_SHIFT_HP) ? S_COS_MUL : S_SHIFT;
        end
      end
      S_COS_MUL: begin
        mac_a          = signed'({1'b0, x_r}) - OFS_W'(MIDPOINT);
        mac_b          = cos_coef(phase_r);
        mac_ctl.mul_en = 1'b1;
        state_nxt      = S_COS_DIV;
      end
      S_COS_DIV: begin
        cneg_nxt  = mac_prod[PROD_W-1];
        cqm_nxt   = CQM_W'(pabs[CMAG_W-1:0]) * CQM_W'(CDIV_MULT);
        state_nxt = S_COS_FIX;
      end
      S_COS_FIX: begin
        if (cv < 0)                    x_nxt = '0;
        else if (cv > CV_W'(SMP_MAX))  x_nxt = SMP_W'(SMP_MAX);
        else                           x_nxt = cv[SMP_W-1:0];
        if (phase_r >= PHASE_W'(COSINE_LENGTH - 1)) phase_nxt = '0;
        else                                        phase_nxt = phase_r + PHASE_W'(1);
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        shift_en = 1'b1;
        fill_nxt = fill_inc;
        tap_nxt  = '0;
        state_nxt = (fill_inc < taps) ? S_IDLE : S_MAC;
      end
      S_MAC: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        mac_ctl.first  = (tap_r == '0);
        if (tap_r == last_tap) state_nxt = S_DRAIN;
        else                   tap_nxt   = tap_r + TAP_W'(1);
      end
      S_DRAIN: begin
        state_nxt = S_DIV_MUL;
      end
      S_DIV_MUL: begin
        dqm_nxt   = FQM_W'(biased[FU_W-1:0]) * FQM_W'(FDIV_MULT);
        state_nxt = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (fy < 0) begin
            out_sample_nxt = '0;
            out_clip_nxt   = 1'b1;
          end else if (fy > FY_W'(SMP_MAX)) begin
            out_sample_nxt = SMP_W'(SMP_MAX);
            out_clip_nxt   = 1'b1;
          end else begin
            out_sample_nxt = fy[SMP_W-1:0];
            out_clip_nxt   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_HP;
      fill_r      <= '0;
      phase_r     <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) delay_r[i] <= SMP_W'(MIDPOINT);
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) mode_r <= mode_t'(cfg_wdata);
      if (shift_en) begin
        for (int i = MAX_TAPS - 1; i > 0; i--) delay_r[i] <= delay_r[i-1];
        delay_r[0] <= x_r;
      end
    end
    x_r          <= x_nxt;
    cqm_r        <= cqm_nxt;
    cneg_r       <= cneg_nxt;
    dqm_r        <= dqm_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_clip_r;

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_TAPS))
    else $error("fill count past window size");

  a_result_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_FIX && state_nxt == S_IDLE) |-> fill_r >= taps)
    else $error("result issued before window full");

  a_phase_mode: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(phase_r)) |-> $past(mode_r) == MODE_SHIFT_HP)
    else $error("cosine phase moved outside shift mode");

  a_mac_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && state_nxt == S_DRAIN) |=> state_r == S_DRAIN ##1 state_r == S_DIV_MUL)
    else $error("accumulate drain sequence broken");
`endif

endmodule
